// ===== hdl/pbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpa_pkg
// Shared widths, codes and control/status bundles of the block pool allocator.
// ----------------------------------------------------------------------------
package pbpa_pkg;

  // pool limits, tied to the handle and count widths of the ports
  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned MAX_PAGES  = 16;

  localparam int unsigned HANDLE_W = 10;  // block handle
  localparam int unsigned COUNT_W  = 11;  // block counts, handle or null
  localparam int unsigned PAGES_W  = 5;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned DSIZE_W  = 13;
  localparam int unsigned PSIZE_W  = 17;
  localparam int unsigned ALIGN_W  = 4;
  localparam int unsigned BLKSZ_W  = 16;  // block size in bytes, up to 32768
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN     = 2'd2;

  localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(MAX_BLOCKS);

  typedef struct packed {
    logic                div_start;
    logic                empty;
    logic                latch_req;
    logic                claim_start;
    logic                claim_step;
    logic                pop_commit;
    logic                free_push;
    logic                status_we;
    logic [STATUS_W-1:0] status;
    logic                load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             cfg_hit;
    logic             div_done;
    logic [CMD_W-1:0] req_cmd;
    logic             head_null;
    logic             bpp_zero;
    logic             no_room;
    logic             free_bad;
    logic             claim_last;
  } ctrl_sts_t;

endpackage

// ===== hdl/pbpa_req_if.sv =====
// ----------------------------------------------------------------------------
// pbpa_req_if
// Request channel: command and block handle with valid/ready.
// ----------------------------------------------------------------------------
interface pbpa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [9:0] block_index;

  modport source (output valid, command, block_index, input ready);
  modport sink   (input valid, command, block_index, output ready);
endinterface

// ===== hdl/pbpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pbpa_rsp_if
// Result channel: status, grant and pool counts with valid/ready.
// ----------------------------------------------------------------------------
interface pbpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  granted_index;
  logic [19:0] byte_offset;
  logic [10:0] free_count;
  logic [10:0] total_blocks;
  logic [4:0]  page_count;

  modport source (output valid, status, granted_index, byte_offset, free_count,
                  total_blocks, page_count, input ready);
  modport sink   (input valid, status, granted_index, byte_offset, free_count,
                  total_blocks, page_count, output ready);
endinterface

// ===== hdl/paged_block_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// paged_block_pool_allocator_top
// Fixed-size block pool with a linked free list over claimed pages.
// ----------------------------------------------------------------------------
// Requests arrive on req (command, block_index), results leave on rsp with
// one result per request; both are valid/ready, a transfer happens when both
// are high. Registers are written through cfg_we/cfg_index/cfg_data.
// After reset, and after the cycle of any register write (req.ready is low
// in that cycle too), req.ready stays low until the blocks-per-page divide
// is done, and the pool starts empty.
// Steps from request to result in the output register:
//   free, free all, unused command, errors: decode, then result
//   allocate from the free list: decode, head read, pop, then result
//   allocate that claims a page: decode, then a page walk with one link and
//   one offset written per cycle, then head read, pop and result
// The list head is read from a 1024-entry link memory with a registered
// read, which sets the pop cost. Block offsets are stored at page claim.
// The result sits in an output register; a stalled receiver holds it, and
// the block stops taking requests once its next result is ready.
// ----------------------------------------------------------------------------
module paged_block_pool_allocator_top #(
  parameter int unsigned LINK_HEADER_BYTES = 8,
  parameter int unsigned PAGE_HEADER_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  pbpa_req_if.sink                        req,
  pbpa_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [pbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbpa_pkg::CFG_W-1:0]      cfg_data
);
  import pbpa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbpa_dp #(
    .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
    .PAGE_HEADER_BYTES (PAGE_HEADER_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (req.command),
    .in_block_index    (req.block_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (rsp.status),
    .out_granted_index (rsp.granted_index),
    .out_byte_offset   (rsp.byte_offset),
    .out_free_count    (rsp.free_count),
    .out_total_blocks  (rsp.total_blocks),
    .out_page_count    (rsp.page_count)
  );

endmodule

// ===== hdl/pbpa_div.sv =====
// ----------------------------------------------------------------------------
// pbpa_div
// Restoring divider, one quotient bit per cycle, for blocks per page.
// ----------------------------------------------------------------------------
module pbpa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pbpa_pkg::PSIZE_W-1:0]  dividend,
  input  logic [pbpa_pkg::BLKSZ_W-1:0]  divisor,
  output logic                          done,
  output logic [pbpa_pkg::PSIZE_W-1:0]  quotient
);
  import pbpa_pkg::*;

  localparam int unsigned CNT_W = $clog2(PSIZE_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [PSIZE_W-1:0]   num;
  logic [BLKSZ_W-1:0]   den;
  logic [BLKSZ_W-1:0]   rem;
  logic [BLKSZ_W:0]     rem_shift;
  logic                 fits;
  logic [BLKSZ_W:0]     rem_sub;

  assign rem_shift = {rem, num[PSIZE_W-1]};
  assign fits      = rem_shift >= {1'b0, den};
  assign rem_sub   = rem_shift - {1'b0, den};
  assign done      = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PSIZE_W - 1);
    end else if (busy) begin
      busy <= (cnt != '0);
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[PSIZE_W-2:0], 1'b0};
      // remainder stays below the divisor, so the low bits are enough
      rem      <= fits ? rem_sub[BLKSZ_W-1:0] : rem_shift[BLKSZ_W-1:0];
      quotient <= {quotient[PSIZE_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/pbpa_dp.sv =====
// ----------------------------------------------------------------------------
// pbpa_dp
// Datapath: config registers, free list memories, counters and result regs.
// ----------------------------------------------------------------------------
module pbpa_dp #(
  parameter int unsigned LINK_HEADER_BYTES = 8,
  parameter int unsigned PAGE_HEADER_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbpa_pkg::CFG_W-1:0]        cfg_data,
  input  logic [pbpa_pkg::CMD_W-1:0]        in_command,
  input  logic [pbpa_pkg::HANDLE_W-1:0]     in_block_index,
  input  pbpa_pkg::ctrl_cmd_t               cmd,
  output pbpa_pkg::ctrl_sts_t               sts,
  output logic [pbpa_pkg::STATUS_W-1:0]     out_status,
  output logic [pbpa_pkg::HANDLE_W-1:0]     out_granted_index,
  output logic [pbpa_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic [pbpa_pkg::COUNT_W-1:0]      out_free_count,
  output logic [pbpa_pkg::COUNT_W-1:0]      out_total_blocks,
  output logic [pbpa_pkg::PAGES_W-1:0]      out_page_count
);
  import pbpa_pkg::*;

  localparam logic [DSIZE_W-1:0] LINK_HDR = DSIZE_W'(LINK_HEADER_BYTES);
  localparam logic [PSIZE_W-1:0] PAGE_HDR = PSIZE_W'(PAGE_HEADER_BYTES);
  localparam logic [COUNT_W-1:0] MAX_BLK  = COUNT_W'(MAX_BLOCKS);
  localparam logic [PAGES_W-1:0] MAX_PG   = PAGES_W'(MAX_PAGES);

  // configuration
  logic [DSIZE_W-1:0]  user_bytes;
  logic [PSIZE_W-1:0]  page_bytes;
  logic [ALIGN_W-1:0]  align_log2;

  // block geometry
  logic [DSIZE_W-1:0]  need;
  logic [BLKSZ_W-1:0]  align_mask;
  logic [BLKSZ_W:0]    need_up;
  logic [BLKSZ_W-1:0]  blk_bytes_c;
  logic [PSIZE_W-1:0]  usable;
  logic [BLKSZ_W-1:0]  blk_bytes;
  logic [PSIZE_W-1:0]  bpp;
  logic                div_done;

  // pool state
  logic [COUNT_W-1:0]  head;
  logic [PAGES_W-1:0]  pages;
  logic [COUNT_W-1:0]  total;
  logic [COUNT_W-1:0]  nfree;
  logic [OFFSET_W-1:0] page_base;

  // request and page walk
  logic [CMD_W-1:0]    req_cmd;
  logic [HANDLE_W-1:0] req_idx;
  logic [HANDLE_W-1:0] cur;
  logic [COUNT_W-1:0]  remain;
  logic [OFFSET_W-1:0] ocur;
  logic                claim_last;

  // free list memories
  logic [COUNT_W-1:0]  link_mem [MAX_BLOCKS];
  logic [OFFSET_W-1:0] off_mem  [MAX_BLOCKS];
  logic [COUNT_W-1:0]  link_q;
  logic [OFFSET_W-1:0] off_q;

  // result
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_granted;
  logic [OFFSET_W-1:0] res_off;

  assign need        = (user_bytes > LINK_HDR) ? user_bytes : LINK_HDR;
  assign align_mask  = (BLKSZ_W'(1) << align_log2) - 1'b1;
  assign need_up     = {{(BLKSZ_W + 1 - DSIZE_W){1'b0}}, need} + {1'b0, align_mask};
  assign blk_bytes_c = need_up[BLKSZ_W-1:0] & ~align_mask;
  assign usable      = (page_bytes > PAGE_HDR) ? (page_bytes - PAGE_HDR) : '0;

  pbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (usable),
    .divisor  (blk_bytes_c),
    .done     (div_done),
    .quotient (bpp)
  );

  assign claim_last = (remain == '0);

  always_comb begin
    sts.cfg_hit    = cfg_we && (cfg_index == REG_DATA_SIZE || cfg_index == REG_PAGE_SIZE ||
                                cfg_index == REG_ALIGN);
    sts.div_done   = div_done;
    sts.req_cmd    = req_cmd;
    sts.head_null  = head[COUNT_W-1];
    sts.bpp_zero   = (bpp == '0);
    sts.no_room    = (pages >= MAX_PG) ||
                     (bpp > {{(PSIZE_W - COUNT_W){1'b0}}, MAX_BLK - total});
    sts.free_bad   = ({1'b0, req_idx} >= total) || (nfree >= total);
    sts.claim_last = claim_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_bytes <= DSIZE_W'(16);
      page_bytes <= PSIZE_W'(4096);
      align_log2 <= ALIGN_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_SIZE: user_bytes <= cfg_data[DSIZE_W-1:0];
        REG_PAGE_SIZE: page_bytes <= cfg_data[PSIZE_W-1:0];
        REG_ALIGN:     align_log2 <= cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      blk_bytes <= blk_bytes_c;
    end
  end

  // pool counters and list head
  always_ff @(posedge clk) begin
    if (rst || cmd.empty) begin
      head      <= NULL_LINK;
      pages     <= '0;
      total     <= '0;
      nfree     <= '0;
      page_base <= '0;
    end else if (cmd.claim_step && claim_last) begin
      head      <= total;
      pages     <= pages + 1'b1;
      total     <= total + bpp[COUNT_W-1:0];
      nfree     <= nfree + bpp[COUNT_W-1:0];
      page_base <= page_base + OFFSET_W'(page_bytes);
    end else if (cmd.pop_commit) begin
      head <= link_q;
      if (nfree != '0) begin
        nfree <= nfree - 1'b1;
      end
    end else if (cmd.free_push) begin
      head  <= {1'b0, req_idx};
      nfree <= nfree + 1'b1;
    end
  end

  // page walk cursors
  always_ff @(posedge clk) begin
    if (cmd.claim_start) begin
      cur    <= total[HANDLE_W-1:0];
      remain <= bpp[COUNT_W-1:0] - 1'b1;
      ocur   <= page_base + OFFSET_W'(PAGE_HEADER_BYTES);
    end else if (cmd.claim_step) begin
      cur    <= cur + 1'b1;
      remain <= remain - 1'b1;
      ocur   <= ocur + OFFSET_W'(blk_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim_step) begin
      link_mem[cur] <= claim_last ? NULL_LINK : ({1'b0, cur} + 1'b1);
      off_mem[cur]  <= ocur;
    end else if (cmd.free_push) begin
      link_mem[req_idx] <= head;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[head[HANDLE_W-1:0]];
    off_q  <= off_mem[head[HANDLE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_cmd     <= in_command;
      req_idx     <= in_block_index;
      res_status  <= ST_OK;
      res_granted <= '0;
      res_off     <= '0;
    end else begin
      if (cmd.status_we) begin
        res_status <= cmd.status;
      end
      if (cmd.pop_commit) begin
        res_granted <= head[HANDLE_W-1:0];
        res_off     <= off_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= res_status;
      out_granted_index <= res_granted;
      out_byte_offset   <= res_off;
      out_free_count    <= nfree;
      out_total_blocks  <= total;
      out_page_count    <= pages;
    end
  end

endmodule

// ===== hdl/pbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbpa_ctrl
// Controller: sequences geometry setup, allocate, free and the output register.
// ----------------------------------------------------------------------------
module pbpa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pbpa_pkg::ctrl_sts_t  sts,
  output pbpa_pkg::ctrl_cmd_t  cmd
);
  import pbpa_pkg::*;

  localparam logic [2:0] S_DIV_START = 3'd0;
  localparam logic [2:0] S_DIV_RUN   = 3'd1;
  localparam logic [2:0] S_IDLE      = 3'd2;
  localparam logic [2:0] S_DECODE    = 3'd3;
  localparam logic [2:0] S_CLAIM     = 3'd4;
  localparam logic [2:0] S_POP_RD    = 3'd5;
  localparam logic [2:0] S_POP_DONE  = 3'd6;
  localparam logic [2:0] S_RESULT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // no request is taken in the cycle of a register write
  assign in_ready = (state == S_IDLE) && !sts.cfg_hit;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        cmd.empty     = 1'b1;
        state_next    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts.div_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESULT;
        case (sts.req_cmd)
          CMD_ALLOC: begin
            if (!sts.head_null) begin
              state_next = S_POP_RD;
            end else if (sts.bpp_zero) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_TOO_SMALL;
            end else if (sts.no_room) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_EXHAUSTED;
            end else begin
              cmd.claim_start = 1'b1;
              state_next      = S_CLAIM;
            end
          end
          CMD_FREE: begin
            if (sts.free_bad) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_BAD_INDEX;
            end else begin
              cmd.free_push = 1'b1;
            end
          end
          CMD_FREE_ALL: cmd.empty = 1'b1;
          default: ;
        endcase
      end
      S_CLAIM: begin
        cmd.claim_step = 1'b1;
        if (sts.claim_last) begin
          state_next = S_POP_RD;
        end
      end
      // head entry is read from memory here
      S_POP_RD: state_next = S_POP_DONE;
      S_POP_DONE: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_DIV_START;
    endcase
    // a register write empties the pool and recomputes the geometry
    if (sts.cfg_hit) begin
      cmd        = '0;
      state_next = S_DIV_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_DIV_START;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
